// ----- hw/rtl/sss_pkg.sv -----
// sphere sector sampler package: constants, register indexes, word and cell types
// used by sss_cell and sphere_sector_point_sampler; no dependencies
package sss_pkg;

    localparam int UNIFORM_BITS  = 24;
    localparam int CORDIC_STAGES = 20;
    localparam int SQRT_STEPS    = 23;   // root bits of a 45-bit radicand
    localparam int NCELL         = (SQRT_STEPS > CORDIC_STAGES) ? SQRT_STEPS : CORDIC_STAGES;
    localparam int CELL_IDX_W    = $clog2(NCELL);

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [23:0] ONE_Q22      = 24'sd4194304;
    localparam logic [45:0]        ONE_SQ       = 46'd1 << 44;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_COS_START = 3'd4,
        REG_COS_END   = 3'd5,
        REG_AZ_START  = 3'd6,
        REG_AZ_END    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] uniform_polar;
        logic [23:0] uniform_azimuth;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } out_word_t;

    // state handed from cell to cell
    typedef struct packed {
        logic [45:0]        rem;
        logic [45:0]        root;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic signed [23:0] ct;
        logic               flip;
    } cell_t;

endpackage

// ----- hw/rtl/sss_cell.sv -----
// one cell of the chain: a square root digit step and, in the first CORDIC_STAGES cells, a cordic rotation step
// depends on sss_pkg
module sss_cell
    import sss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CELL_IDX_W-1:0] idx,
    input  logic                  ld,
    input  logic                  in_valid,
    input  cell_t                 in_word,
    output logic                  out_valid,
    output cell_t                 out_word
);

    logic  valid_reg;
    cell_t word_reg;
    cell_t word_next;

    logic [5:0]         sh;
    logic [45:0]        bitv;
    logic [45:0]        trial;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;

    always_comb begin
        word_next = in_word;
        sh    = 6'(2 * (SQRT_STEPS - 1)) - {{(5 - CELL_IDX_W){1'b0}}, idx, 1'b0};
        bitv  = 46'd1 << sh;
        trial = in_word.root + bitv;
        dx    = in_word.y >>> idx;
        dy    = in_word.x >>> idx;
        at    = 33'($signed({1'b0, ATAN_TURNS[5'(idx)]}));
        if (int'(idx) < SQRT_STEPS) begin
            if (in_word.rem >= trial) begin
                word_next.rem  = in_word.rem - trial;
                word_next.root = (in_word.root >> 1) + bitv;
            end else begin
                word_next.root = in_word.root >> 1;
            end
        end
        if (int'(idx) < CORDIC_STAGES) begin
            if (!in_word.z[32]) begin
                word_next.x = in_word.x - dx;
                word_next.y = in_word.y + dy;
                word_next.z = in_word.z - at;
            end else begin
                word_next.x = in_word.x + dx;
                word_next.y = in_word.y - dy;
                word_next.z = in_word.z + at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ld) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- hw/rtl/sphere_sector_point_sampler.sv -----
// sphere sector point sampler top level: blend front end, cell chain, scaling back end
// depends on sss_pkg and sss_cell
//
// usage
// - s_valid/s_ready/s_data carry one word of two uniform fractions
// - m_valid/m_ready/m_data carry one word with the sampled point x, y, z
// - cfg_we/cfg_index/cfg_wdata write the eight setup registers, no read-back;
//   write them only while the block holds no words
// - stages: three front stages (blend products, blend sums and
//   angle fold, cosine square), 23 chain cells (one root bit each, the first
//   20 also run one cordic rotation), three back stages (radius scaling,
//   trig products, offset add and saturate)
// - throughput is one word per cycle; every stage is a register with its
//   own valid bit, so bubbles close up and a word enters as long as some
//   stage downstream has room
// - when m_ready is low the output register holds its word and the chain
//   keeps filling behind it until all stages are full, then s_ready drops
// - reset clears all valid bits and loads the register reset values (unit
//   sphere at the origin, full polar and azimuth range)
module sphere_sector_point_sampler
    import sss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam logic [23:0] UMASK = (UNIFORM_BITS >= 24) ? 24'hFF_FFFF
                                                         : 24'((64'd1 << UNIFORM_BITS) - 1);

    // setup registers
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [30:0]        radius_reg;
    logic signed [23:0] cos_start_reg, cos_end_reg;
    logic signed [17:0] az_start_reg, az_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= 31'd65536;
            cos_start_reg <= ONE_Q22;
            cos_end_reg   <= -ONE_Q22;
            az_start_reg  <= '0;
            az_end_reg    <= 18'sd65536;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CENTER_X:  center_x_reg  <= cfg_wdata;
                REG_CENTER_Y:  center_y_reg  <= cfg_wdata;
                REG_CENTER_Z:  center_z_reg  <= cfg_wdata;
                REG_RADIUS:    radius_reg    <= cfg_wdata[30:0];
                REG_COS_START: cos_start_reg <= cfg_wdata[23:0];
                REG_COS_END:   cos_end_reg   <= cfg_wdata[23:0];
                REG_AZ_START:  az_start_reg  <= cfg_wdata[17:0];
                REG_AZ_END:    az_end_reg    <= cfg_wdata[17:0];
            endcase
        end
    end

    // stage valid bits and load enables
    logic p1_v_reg, p2_v_reg, p3_v_reg, q1_v_reg, q2_v_reg, q3_v_reg;
    logic ld_p1, ld_p2, ld_p3, ld_q1, ld_q2, ld_q3;
    logic [NCELL-1:0] cell_v, cell_ld;

    assign ld_q3   = !q3_v_reg || m_ready;
    assign ld_q2   = !q2_v_reg || ld_q3;
    assign ld_q1   = !q1_v_reg || ld_q2;
    assign ld_p3   = !p3_v_reg || cell_ld[0];
    assign ld_p2   = !p2_v_reg || ld_p3;
    assign ld_p1   = !p1_v_reg || ld_p2;
    assign s_ready = ld_p1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            q3_v_reg <= 1'b0;
        end else begin
            if (ld_p1) p1_v_reg <= s_valid;
            if (ld_p2) p2_v_reg <= p1_v_reg;
            if (ld_p3) p3_v_reg <= p2_v_reg;
            if (ld_q1) q1_v_reg <= cell_v[NCELL-1];
            if (ld_q2) q2_v_reg <= q1_v_reg;
            if (ld_q3) q3_v_reg <= q2_v_reg;
        end
    end

    // p1: blend products (end - start) * fraction
    logic signed [49:0] cprod_reg;
    logic signed [43:0] aprod_reg;
    logic signed [24:0] dcos;
    logic signed [18:0] daz;
    logic [23:0]        u_m, v_m;

    assign dcos = 25'(cos_end_reg) - 25'(cos_start_reg);
    assign daz  = 19'(az_end_reg) - 19'(az_start_reg);
    assign u_m  = s_data.uniform_polar & UMASK;
    assign v_m  = s_data.uniform_azimuth & UMASK;

    always_ff @(posedge aclk) begin
        if (ld_p1 && s_valid) begin
            cprod_reg <= 50'(dcos) * 50'($signed({1'b0, u_m}));
            aprod_reg <= 44'(daz) * 44'($signed({1'b0, v_m}));
        end
    end

    // p2: blend sums, cosine clamp, fold angle into the right half plane
    logic signed [26:0] ct_raw;
    logic signed [23:0] ct_c;
    logic signed [19:0] phi;
    logic [31:0]        ang, ang_f;
    logic               flip;
    logic signed [23:0] p2_ct_reg;
    logic signed [32:0] p2_z_reg;
    logic               p2_flip_reg;

    always_comb begin
        ct_raw = 27'(cos_start_reg) + 27'(cprod_reg >>> UNIFORM_BITS);
        if (ct_raw > 27'(ONE_Q22)) begin
            ct_c = ONE_Q22;
        end else if (ct_raw < -27'(ONE_Q22)) begin
            ct_c = -ONE_Q22;
        end else begin
            ct_c = ct_raw[23:0];
        end
        phi   = 20'(az_start_reg) + 20'(aprod_reg >>> UNIFORM_BITS);
        ang   = {phi[15:0], 16'd0};
        flip  = ang[31] ^ ang[30];
        ang_f = flip ? (ang - 32'h8000_0000) : ang;
    end

    always_ff @(posedge aclk) begin
        if (ld_p2 && p1_v_reg) begin
            p2_ct_reg   <= ct_c;
            p2_z_reg    <= 33'($signed(ang_f));
            p2_flip_reg <= flip;
        end
    end

    // p3: radicand 1 - ct^2 and chain start vector
    logic signed [47:0] ct_sq;
    cell_t              p3_reg;

    assign ct_sq = 48'(p2_ct_reg) * 48'(p2_ct_reg);

    always_ff @(posedge aclk) begin
        if (ld_p3 && p2_v_reg) begin
            p3_reg.rem  <= ONE_SQ - ct_sq[45:0];
            p3_reg.root <= '0;
            p3_reg.x    <= CORDIC_START;
            p3_reg.y    <= '0;
            p3_reg.z    <= p2_z_reg;
            p3_reg.ct   <= p2_ct_reg;
            p3_reg.flip <= p2_flip_reg;
        end
    end

    // cell chain: square root and cordic side by side
    cell_t cell_w [NCELL];

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == NCELL - 1) begin : g_last
            assign cell_ld[k] = !cell_v[k] || ld_q1;
        end else begin : g_mid
            assign cell_ld[k] = !cell_v[k] || cell_ld[k+1];
        end
        if (k == 0) begin : g_first
            sss_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .idx       (CELL_IDX_W'(k)),
                .ld        (cell_ld[k]),
                .in_valid  (p3_v_reg),
                .in_word   (p3_reg),
                .out_valid (cell_v[k]),
                .out_word  (cell_w[k])
            );
        end else begin : g_next
            sss_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .idx       (CELL_IDX_W'(k)),
                .ld        (cell_ld[k]),
                .in_valid  (cell_v[k-1]),
                .in_word   (cell_w[k-1]),
                .out_valid (cell_v[k]),
                .out_word  (cell_w[k])
            );
        end
    end

    // q1: scale by radius, undo the half-plane fold
    cell_t              tail;
    logic [53:0]        rs_prod;
    logic signed [55:0] z_prod;
    logic [31:0]        q1_rs_reg;
    logic signed [33:0] q1_c_reg, q1_s_reg, q1_zoff_reg;

    assign tail    = cell_w[NCELL-1];
    assign rs_prod = 54'(radius_reg) * 54'(tail.root[22:0]);
    assign z_prod  = 56'($signed({1'b0, radius_reg})) * 56'(tail.ct);

    always_ff @(posedge aclk) begin
        if (ld_q1 && cell_v[NCELL-1]) begin
            q1_rs_reg   <= rs_prod[53:22];
            q1_c_reg    <= tail.flip ? -tail.x : tail.x;
            q1_s_reg    <= tail.flip ? -tail.y : tail.y;
            q1_zoff_reg <= 34'(z_prod >>> 22);
        end
    end

    // q2: radius times cosine and sine
    logic signed [66:0] xp, yp;
    logic signed [36:0] q2_x_reg, q2_y_reg;
    logic signed [33:0] q2_zoff_reg;

    assign xp = 67'($signed({1'b0, q1_rs_reg})) * 67'(q1_c_reg);
    assign yp = 67'($signed({1'b0, q1_rs_reg})) * 67'(q1_s_reg);

    always_ff @(posedge aclk) begin
        if (ld_q2 && q1_v_reg) begin
            q2_x_reg    <= 37'(xp >>> 30);
            q2_y_reg    <= 37'(yp >>> 30);
            q2_zoff_reg <= q1_zoff_reg;
        end
    end

    // q3: add center, saturate, output register
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    out_word_t q3_reg;

    always_ff @(posedge aclk) begin
        if (ld_q3 && q2_v_reg) begin
            q3_reg.point_x <= sat32(38'(center_x_reg) + 38'(q2_x_reg));
            q3_reg.point_y <= sat32(38'(center_y_reg) + 38'(q2_y_reg));
            q3_reg.point_z <= sat32(38'(center_z_reg) + 38'(q2_zoff_reg));
        end
    end

    assign m_valid = q3_v_reg;
    assign m_data  = q3_reg;

endmodule
